/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check while out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check through reset as well
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/tcdr_pkg.sv */
// ---------------------------------------------------------------------------
// tcdr_pkg
// Shared types, codes and helpers of the text cell display renderer.
// ---------------------------------------------------------------------------
`default_nettype none

package tcdr_pkg;

  typedef enum logic [1:0] {
    OP_FONT    = 2'd0,
    OP_PALETTE = 2'd1,
    OP_FRAME   = 2'd2,
    OP_RENDER  = 2'd3
  } op_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_INDEX   = 2'd1;

  localparam logic [4:0] PIX_LAST  = 5'd31;
  localparam logic [7:0] ALPHA_MAX = 8'hFF;

  typedef struct packed {
    logic [31:0] glyph;
    logic [11:0] fg;
    logic [11:0] bg;
  } tile_entry_t;

  // each nibble times 0x11
  function automatic logic [23:0] widen_color(input logic [11:0] c);
    return {c[11:8], c[11:8], c[7:4], c[7:4], c[3:0], c[3:0]};
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tcdr_if.sv */
// ---------------------------------------------------------------------------
// tcdr channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface tcdr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  store_addr;
  logic [15:0] store_data;
  logic        toggle_blink;
  logic [3:0]  tile_row;
  logic [4:0]  tile_col;
  logic [15:0] cell_word;

  modport source (output valid, op, store_addr, store_data, toggle_blink,
                  tile_row, tile_col, cell_word, input ready);
  modport sink   (input valid, op, store_addr, store_data, toggle_blink,
                  tile_row, tile_col, cell_word, output ready);
endinterface

interface tcdr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [6:0]  pixel_x;
  logic [6:0]  pixel_y;
  logic [31:0] color_rgba;
  logic        last;

  modport source (output valid, kind, pixel_x, pixel_y, color_rgba, last,
                  input ready);
  modport sink   (input valid, kind, pixel_x, pixel_y, color_rgba, last,
                  output ready);
endinterface

interface tcdr_cfg_if;
  import tcdr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/text_cell_display_renderer.sv */
// ---------------------------------------------------------------------------
// text_cell_display_renderer
// Character-cell renderer with font, palette and per-tile cache memories.
// ---------------------------------------------------------------------------
// in_port  : items (font write, palette write, start frame, render cell).
// out_port : pixels and border reports; last marks the final result of an item.
// cfg_port : register writes (display_enable, border_index), always ready.
// Writes and cached cells give no result. A start frame gives one border
// report; a redrawn cell gives 32 pixels, column by column, one per cycle
// while the receiver is ready, from the single pixel serialiser. The first
// result passes through the memory read registers, then the serialiser
// register.
// Font, palette and tile cache are read in the accept cycle and the cache is
// written back when the item leaves the decode stage, with forwarding of the
// last write-back to the following item.
// After reset a clearing pass zeroes all TILE_ROWS*TILE_COLS tile cache
// entries (384 by default), with in_port.ready low; register writes are taken.
// When the receiver stalls the current result holds, the serialiser holds and
// one further item may wait in the decode stage before in_port.ready drops.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module text_cell_display_renderer #(
  parameter int unsigned TILE_COLS   = 32,
  parameter int unsigned TILE_ROWS   = 12,
  parameter int unsigned GLYPH_COUNT = 128
) (
  input  wire       clk,
  input  wire       rst_n,
  tcdr_in_if.sink   in_port,
  tcdr_out_if.source out_port,
  tcdr_cfg_if.sink  cfg_port
);
  import tcdr_pkg::*;

  localparam int unsigned FONT_WORDS = 2 * GLYPH_COUNT;
  localparam int unsigned FA_W       = $clog2(FONT_WORDS);
  localparam int unsigned TILE_COUNT = TILE_ROWS * TILE_COLS;
  localparam int unsigned TA_W       = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;

  logic [15:0]       font_mem  [FONT_WORDS];
  logic [11:0]       pal_mem   [16];
  tile_entry_t       cache_mem [TILE_COUNT];

  logic              display_enable_r;
  logic [3:0]        border_index_r;
  logic              blink_phase_r;
  logic              force_redraw_r;

  logic              clr_busy_r;
  logic [TA_W-1:0]   clr_cnt_r;

  logic              s1_valid_r;
  op_t               s1_op_r;
  logic              s1_en_r;
  logic              s1_ch_ok_r;
  logic              s1_blink_r;
  logic              s1_toggle_r;
  logic [3:0]        s1_row_r;
  logic [4:0]        s1_col_r;
  logic [TA_W-1:0]   s1_t_r;
  logic [15:0]       font_hi_q_r;
  logic [15:0]       font_lo_q_r;
  logic [11:0]       pal_a_q_r;
  logic [11:0]       pal_b_q_r;
  tile_entry_t       cache_q_r;

  logic              fwd_valid_r;
  logic [TA_W-1:0]   fwd_addr_r;
  tile_entry_t       fwd_data_r;

  logic              ser_valid_r;
  logic              ser_kind_r;
  logic [31:0]       ser_glyph_r;
  logic [23:0]       ser_fg_r;
  logic [23:0]       ser_bg_r;
  logic [3:0]        ser_row_r;
  logic [4:0]        ser_col_r;
  logic [4:0]        ser_cnt_r;

  logic              in_accept;
  op_t               in_op;
  logic [7:0]        fa_full;
  logic [FA_W-1:0]   fa_hi;
  logic [FA_W-1:0]   fa_lo;
  logic [3:0]        pal_ra;
  logic [11:0]       t_full;
  logic [TA_W-1:0]   t_idx;
  logic              in_range;

  logic [31:0]       glyph;
  tile_entry_t       old_entry;
  tile_entry_t       new_entry;
  logic              hit;
  logic              need_out;
  logic              s1_fire;
  logic              cache_we;
  logic              ser_free;
  logic              ser_load;
  logic              out_last;
  logic              out_accept;
  logic              solid;

  // ---------------- input side ----------------
  assign in_op     = op_t'(in_port.op);
  assign in_accept = in_port.valid && in_port.ready;
  assign in_port.ready = !clr_busy_r && (!s1_valid_r || s1_fire);

  assign fa_full = {in_port.cell_word[6:0], 1'b0};
  assign fa_hi   = fa_full[FA_W-1:0];
  assign fa_lo   = fa_hi | FA_W'(1);
  assign pal_ra  = (in_op == OP_FRAME) ? border_index_r : in_port.cell_word[15:12];
  assign t_full  = 12'(in_port.tile_row) * 12'(TILE_COLS) + 12'(in_port.tile_col);
  assign t_idx   = t_full[TA_W-1:0];
  assign in_range = (7'(in_port.tile_row) < 7'(TILE_ROWS)) &&
                    (7'(in_port.tile_col) < 7'(TILE_COLS));

  // ---------------- configuration ----------------
  assign cfg_port.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_enable_r <= 1'b0;
      border_index_r   <= 4'd0;
    end else if (cfg_port.valid) begin
      case (cfg_port.index)
        CFG_DISPLAY_ENABLE: display_enable_r <= cfg_port.data[0];
        CFG_BORDER_INDEX:   border_index_r   <= cfg_port.data[3:0];
        default: ;
      endcase
    end
  end

  // ---------------- font and palette memories ----------------
  always_ff @(posedge clk) begin
    if (in_accept && in_op == OP_FONT && 9'(in_port.store_addr) < 9'(FONT_WORDS)) begin
      font_mem[in_port.store_addr[FA_W-1:0]] <= in_port.store_data;
    end
    if (in_accept) begin
      font_hi_q_r <= font_mem[fa_hi];
      font_lo_q_r <= font_mem[fa_lo];
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_op == OP_PALETTE && in_port.store_addr[7:4] == 4'd0) begin
      pal_mem[in_port.store_addr[3:0]] <= in_port.store_data[11:0];
    end
    if (in_accept) begin
      pal_a_q_r <= pal_mem[pal_ra];
      pal_b_q_r <= pal_mem[in_port.cell_word[11:8]];
    end
  end

  // ---------------- tile cache memory ----------------
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      cache_mem[clr_cnt_r] <= '0;
    end else if (cache_we) begin
      cache_mem[s1_t_r] <= new_entry;
    end
    if (in_accept) begin
      cache_q_r <= cache_mem[t_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == TA_W'(TILE_COUNT - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + TA_W'(1);
    end
  end

  // ---------------- decode stage ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r     <= in_op;
      s1_en_r     <= display_enable_r && in_range;
      s1_ch_ok_r  <= 8'(in_port.cell_word[6:0]) < 8'(GLYPH_COUNT);
      s1_blink_r  <= in_port.cell_word[7];
      s1_toggle_r <= in_port.toggle_blink;
      s1_row_r    <= in_port.tile_row;
      s1_col_r    <= in_port.tile_col;
      s1_t_r      <= t_idx;
    end
  end

  always_comb begin
    glyph = s1_ch_ok_r ? {font_hi_q_r, font_lo_q_r} : 32'h0000_0000;
    if (s1_blink_r && !blink_phase_r) begin
      glyph = 32'h0000_0000;
    end
    old_entry = (fwd_valid_r && fwd_addr_r == s1_t_r) ? fwd_data_r : cache_q_r;
    new_entry = '{glyph: glyph, fg: pal_a_q_r, bg: pal_b_q_r};
    hit       = (old_entry == new_entry) && !force_redraw_r;
    need_out  = (s1_op_r == OP_FRAME) || (s1_op_r == OP_RENDER && s1_en_r && !hit);
    s1_fire   = s1_valid_r && (!need_out || ser_free);
    cache_we  = s1_fire && s1_op_r == OP_RENDER && s1_en_r && !hit;
    ser_load  = s1_fire && need_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_phase_r  <= 1'b0;
      force_redraw_r <= 1'b0;
      fwd_valid_r    <= 1'b0;
    end else if (s1_fire) begin
      fwd_valid_r <= cache_we;
      if (s1_op_r == OP_FRAME) begin
        if (display_enable_r && s1_toggle_r) begin
          blink_phase_r  <= !blink_phase_r;
          force_redraw_r <= 1'b1;
        end else begin
          force_redraw_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      fwd_addr_r <= s1_t_r;
      fwd_data_r <= new_entry;
    end
  end

  // ---------------- pixel serialiser ----------------
  assign out_last   = ser_kind_r || (ser_cnt_r == PIX_LAST);
  assign out_accept = out_port.valid && out_port.ready;
  assign ser_free   = !ser_valid_r || (out_port.ready && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_valid_r <= 1'b0;
      ser_cnt_r   <= 5'd0;
    end else if (ser_load) begin
      ser_valid_r <= 1'b1;
      ser_cnt_r   <= 5'd0;
    end else if (out_accept) begin
      if (out_last) begin
        ser_valid_r <= 1'b0;
      end
      ser_cnt_r <= ser_cnt_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      ser_kind_r  <= (s1_op_r == OP_FRAME);
      ser_glyph_r <= glyph;
      ser_fg_r    <= widen_color(pal_a_q_r);
      ser_bg_r    <= widen_color(pal_b_q_r);
      ser_row_r   <= (s1_op_r == OP_FRAME) ? 4'd0 : s1_row_r;
      ser_col_r   <= (s1_op_r == OP_FRAME) ? 5'd0 : s1_col_r;
    end
  end

  assign solid = ser_glyph_r[{~ser_cnt_r[4:3], ser_cnt_r[2:0]}];

  assign out_port.valid      = ser_valid_r;
  assign out_port.kind       = ser_kind_r;
  assign out_port.pixel_x    = {ser_col_r, ser_cnt_r[4:3]};
  assign out_port.pixel_y    = {ser_row_r, ser_cnt_r[2:0]};
  assign out_port.color_rgba = {(ser_kind_r || solid) ? ser_fg_r : ser_bg_r, ALPHA_MAX};
  assign out_port.last       = out_last;

  // ---------------- assertions ----------------
  `ASSERT_ALWAYS(a_reset_blocks_input, !rst_n |=> !in_port.ready, "input open after reset")
  `ASSERT_CLK(a_clear_empty_stage, clr_busy_r |-> !s1_valid_r && !ser_valid_r,
              "item in flight during cache clear")
  `ASSERT_CLK(a_border_single, ser_valid_r && ser_kind_r |-> ser_cnt_r == 5'd0,
              "border report advanced past first result")
  `ASSERT_CLK(a_writes_no_stall,
              s1_valid_r && (s1_op_r == OP_FONT || s1_op_r == OP_PALETTE) |-> s1_fire,
              "store write transaction stalled")

endmodule

`default_nettype wire
